// ----- rtl/rc4_keystream_generator_assert.svh -----
// Assertion macros for the RC4 keystream generator.
// Used by the top level; relies on clk and rst_n being in scope.
`ifndef RC4_KEYSTREAM_GENERATOR_ASSERT_SVH
`define RC4_KEYSTREAM_GENERATOR_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define RC4KG_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rc4 keystream generator: check failed");

// Next-cycle implication, held off during reset.
`define RC4KG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rc4 keystream generator: check failed");

`endif

// ----- rtl/rc4kg_pkg.sv -----
// Shared types and constants for the RC4 keystream generator.
// No dependencies; used by every module of the block.
package rc4kg_pkg;

    localparam int PERM_SIZE       = 256;
    localparam int PERM_W          = 8;
    localparam int KEY_LEN_DEFAULT = 16;
    localparam int COUNT_W         = 9;
    localparam int KEY_IDX_W       = 8;
    localparam int Q_DEPTH         = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 9'd511;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_GEN  = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_LEN      = 2'd1;
    localparam logic [1:0] ST_UNKEYED  = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    // Classified item, handed from the front end to the back end.
    typedef struct packed {
        logic                  is_gen;
        logic                  wr_en;
        logic [KEY_IDX_W-1:0]  key_slot;
        logic [7:0]            key_byte;
        logic                  sched;
        logic [1:0]            status;
    } cmd_t;

endpackage

// ----- rtl/rc4kg_front.sv -----
// Front end: accepts items, tracks the key byte count and classifies each item.
// Depends on rc4kg_pkg.
module rc4kg_front
    import rc4kg_pkg::*;
#(
    parameter int KEY_LEN = KEY_LEN_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  logic        opcode,
    input  logic [7:0]  key_byte,
    input  logic        key_last,
    output logic        push,
    output cmd_t        push_cmd,
    input  logic        q_full
);

    logic [COUNT_W-1:0] key_count_reg;
    logic [COUNT_W-1:0] key_count_next;
    logic [COUNT_W-1:0] count_inc;
    logic               room;

    assign cmd_ready = !q_full;
    assign push      = cmd_valid && !q_full;

    always_comb
    begin
        room      = key_count_reg < COUNT_W'(KEY_LEN);
        count_inc = (key_count_reg < COUNT_MAX) ? key_count_reg + 1'b1 : key_count_reg;

        push_cmd.is_gen    = (opcode == OP_GEN);
        push_cmd.wr_en     = 1'b0;
        push_cmd.key_slot  = key_count_reg[KEY_IDX_W-1:0];
        push_cmd.key_byte  = key_byte;
        push_cmd.sched     = 1'b0;
        push_cmd.status    = ST_OK;
        key_count_next     = key_count_reg;

        if (opcode == OP_LOAD)
        begin
            push_cmd.wr_en = room;
            if (key_last)
            begin
                if (count_inc == COUNT_W'(KEY_LEN))
                    push_cmd.sched = 1'b1;
                else
                    push_cmd.status = ST_LEN;
                key_count_next = '0;
            end
            else
            begin
                if (!room)
                    push_cmd.status = ST_OVERFLOW;
                key_count_next = count_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            key_count_reg <= '0;
        else if (push)
            key_count_reg <= key_count_next;
    end

endmodule

// ----- rtl/rc4kg_queue.sv -----
// Short command queue between the front and back ends.
// Depends on rc4kg_pkg.
module rc4kg_queue
    import rc4kg_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output cmd_t head,
    output logic not_empty
);

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    cmd_t             entry_reg [Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full      = (count_reg == CNT_W'(Q_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ----- rtl/rc4kg_back.sv -----
// Back end: key store, permutation memory, key schedule and output sequencer.
// Depends on rc4kg_pkg.
module rc4kg_back
    import rc4kg_pkg::*;
#(
    parameter int KEY_LEN = KEY_LEN_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              head,
    input  logic              not_empty,
    output logic              pop,
    output logic              res_valid,
    input  logic              res_ready,
    output logic [7:0]        stream_byte,
    output logic [1:0]        status,
    output logic              keyed
);

    localparam int KIDX_W = (KEY_LEN > 1) ? $clog2(KEY_LEN) : 1;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_FILL   = 4'd1;
    localparam logic [3:0] S_KSA_RD = 4'd2;
    localparam logic [3:0] S_KSA_J  = 4'd3;
    localparam logic [3:0] S_KSA_W1 = 4'd4;
    localparam logic [3:0] S_KSA_W2 = 4'd5;
    localparam logic [3:0] S_GEN_J  = 4'd6;
    localparam logic [3:0] S_GEN_W1 = 4'd7;
    localparam logic [3:0] S_GEN_W2 = 4'd8;
    localparam logic [3:0] S_GEN_RD = 4'd9;
    localparam logic [3:0] S_DONE   = 4'd10;

    logic [PERM_W-1:0] perm_mem [PERM_SIZE];
    logic [7:0]        key_mem  [KEY_LEN];

    logic [3:0]        state_reg, state_next;
    logic [PERM_W-1:0] i_reg, i_next;
    logic [PERM_W-1:0] j_reg, j_next;
    logic [PERM_W-1:0] si_reg, si_next;
    logic [PERM_W-1:0] sj_reg, sj_next;
    logic [KIDX_W-1:0] kidx_reg, kidx_next;
    logic              keyed_reg, keyed_next;
    logic [1:0]        pend_status_reg, pend_status_next;
    logic              gen_ok_reg, gen_ok_next;

    logic              res_valid_reg, res_valid_next;
    logic [7:0]        stream_reg;
    logic [1:0]        status_reg;
    logic              keyed_out_reg;
    logic              load_out;

    logic              perm_we, perm_re;
    logic [PERM_W-1:0] perm_addr, perm_wdata, perm_rdata_reg;
    logic              key_we, key_re;
    logic [KIDX_W-1:0] key_waddr;
    logic [7:0]        key_wdata, key_rdata_reg;
    logic [PERM_W-1:0] jsum;

    assign res_valid   = res_valid_reg;
    assign stream_byte = stream_reg;
    assign status      = status_reg;
    assign keyed       = keyed_out_reg;

    always_comb
    begin
        state_next       = state_reg;
        i_next           = i_reg;
        j_next           = j_reg;
        si_next          = si_reg;
        sj_next          = sj_reg;
        kidx_next        = kidx_reg;
        keyed_next       = keyed_reg;
        pend_status_next = pend_status_reg;
        gen_ok_next      = gen_ok_reg;
        pop              = 1'b0;
        load_out         = 1'b0;
        perm_we          = 1'b0;
        perm_re          = 1'b0;
        perm_addr        = i_reg;
        perm_wdata       = i_reg;
        key_we           = 1'b0;
        key_re           = 1'b0;
        key_waddr        = head.key_slot[KIDX_W-1:0];
        key_wdata        = head.key_byte;
        jsum             = j_reg + perm_rdata_reg
                           + ((state_reg == S_KSA_J) ? key_rdata_reg : 8'd0);

        case (state_reg)
            S_IDLE:
            begin
                if (not_empty)
                begin
                    pop = 1'b1;
                    if (head.is_gen)
                    begin
                        if (keyed_reg)
                        begin
                            i_next           = i_reg + 1'b1;
                            perm_re          = 1'b1;
                            perm_addr        = i_reg + 1'b1;
                            gen_ok_next      = 1'b1;
                            pend_status_next = ST_OK;
                            state_next       = S_GEN_J;
                        end
                        else
                        begin
                            gen_ok_next      = 1'b0;
                            pend_status_next = ST_UNKEYED;
                            state_next       = S_DONE;
                        end
                    end
                    else
                    begin
                        key_we           = head.wr_en;
                        gen_ok_next      = 1'b0;
                        pend_status_next = head.status;
                        if (head.sched)
                        begin
                            i_next     = '0;
                            state_next = S_FILL;
                        end
                        else
                            state_next = S_DONE;
                    end
                end
            end
            S_FILL:
            begin
                perm_we = 1'b1;
                i_next  = i_reg + 1'b1;
                if (i_reg == '1)
                begin
                    j_next     = '0;
                    kidx_next  = '0;
                    state_next = S_KSA_RD;
                end
            end
            S_KSA_RD:
            begin
                perm_re    = 1'b1;
                key_re     = 1'b1;
                state_next = S_KSA_J;
            end
            S_KSA_J:
            begin
                si_next    = perm_rdata_reg;
                j_next     = jsum;
                perm_re    = 1'b1;
                perm_addr  = jsum;
                state_next = S_KSA_W1;
            end
            S_KSA_W1:
            begin
                perm_we    = 1'b1;
                perm_wdata = perm_rdata_reg;
                state_next = S_KSA_W2;
            end
            S_KSA_W2:
            begin
                perm_we    = 1'b1;
                perm_addr  = j_reg;
                perm_wdata = si_reg;
                i_next     = i_reg + 1'b1;
                kidx_next  = (kidx_reg == KIDX_W'(KEY_LEN - 1)) ? '0 : kidx_reg + 1'b1;
                if (i_reg == '1)
                begin
                    j_next     = '0;
                    keyed_next = 1'b1;
                    state_next = S_DONE;
                end
                else
                    state_next = S_KSA_RD;
            end
            S_GEN_J:
            begin
                si_next    = perm_rdata_reg;
                j_next     = jsum;
                perm_re    = 1'b1;
                perm_addr  = jsum;
                state_next = S_GEN_W1;
            end
            S_GEN_W1:
            begin
                sj_next    = perm_rdata_reg;
                perm_we    = 1'b1;
                perm_wdata = perm_rdata_reg;
                state_next = S_GEN_W2;
            end
            S_GEN_W2:
            begin
                perm_we    = 1'b1;
                perm_addr  = j_reg;
                perm_wdata = si_reg;
                state_next = S_GEN_RD;
            end
            S_GEN_RD:
            begin
                perm_re    = 1'b1;
                perm_addr  = si_reg + sj_reg;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res_valid_next = load_out ? 1'b1 : (res_ready ? 1'b0 : res_valid_reg);

    // Permutation memory: single port, registered read.
    always_ff @(posedge clk)
    begin
        if (perm_we)
            perm_mem[perm_addr] <= perm_wdata;
        else if (perm_re)
            perm_rdata_reg <= perm_mem[perm_addr];
    end

    // Key store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (key_we)
            key_mem[key_waddr] <= key_wdata;
        if (key_re)
            key_rdata_reg <= key_mem[kidx_reg];
    end

    always_ff @(posedge clk)
    begin
        si_reg          <= si_next;
        sj_reg          <= sj_next;
        kidx_reg        <= kidx_next;
        pend_status_reg <= pend_status_next;
        gen_ok_reg      <= gen_ok_next;
        if (load_out)
        begin
            stream_reg <= gen_ok_reg ? perm_rdata_reg : 8'd0;
            status_reg <= pend_status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            keyed_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
            keyed_out_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            keyed_reg     <= keyed_next;
            res_valid_reg <= res_valid_next;
            if (load_out)
                keyed_out_reg <= keyed_reg;
        end
    end

endmodule

// ----- rtl/rc4_keystream_generator.sv -----
// RC4 keystream generator: byte-serial key load, key schedule, keystream output.
// Instantiates rc4kg_front, rc4kg_queue and rc4kg_back; uses rc4kg_pkg and the
// assertion macros in rc4_keystream_generator_assert.svh.
//
// Usage: send key bytes with opcode 0, marking the final one with key_last.
// When exactly KEY_LEN bytes were sent, the last item runs the RC4 key
// schedule and its result reports keyed = 1; a wrong count returns status 1
// and leaves any earlier key in force, and bytes beyond KEY_LEN return
// status 3 and are dropped. Opcode 1 returns one keystream byte per item
// (status 2 and byte 0 while unkeyed). Every item gets exactly one result.
// Timing: the front end takes an item every cycle while its two-entry queue
// has room. The back end works one item at a time on a single-port 256x8
// permutation memory: a keystream byte takes three reads, two writes and a
// final step to issue the result, and the key schedule item runs an identity
// fill pass, then two reads and two writes per schedule step. The result
// register lets the back end finish one more item while a result waits to be
// taken. No clearing pass is needed after reset: the permutation is only read
// once a schedule has rewritten it.
`include "rc4_keystream_generator_assert.svh"

module rc4_keystream_generator
    import rc4kg_pkg::*;
#(
    parameter int KEY_LEN = KEY_LEN_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_ready,
    input  logic       opcode,
    input  logic [7:0] key_byte,
    input  logic       key_last,
    output logic       res_valid,
    input  logic       res_ready,
    output logic [7:0] stream_byte,
    output logic [1:0] status,
    output logic       keyed
);

    // Front end to queue.
    logic push;
    cmd_t push_cmd;
    logic q_full;

    // Queue to back end.
    logic pop;
    cmd_t head;
    logic not_empty;

    rc4kg_front #(
        .KEY_LEN (KEY_LEN)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .opcode    (opcode),
        .key_byte  (key_byte),
        .key_last  (key_last),
        .push      (push),
        .push_cmd  (push_cmd),
        .q_full    (q_full)
    );

    rc4kg_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty)
    );

    // Back end owns the key store, permutation and result register.
    rc4kg_back #(
        .KEY_LEN (KEY_LEN)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .not_empty   (not_empty),
        .pop         (pop),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .stream_byte (stream_byte),
        .status      (status),
        .keyed       (keyed)
    );

    // An unkeyed generate item never reports a key or a byte.
    `RC4KG_ASSERT_IMPL(a_unkeyed_clean, res_valid && (status == ST_UNKEYED), (stream_byte == 8'd0) && !keyed)
    // Error results carry no keystream byte.
    `RC4KG_ASSERT_IMPL(a_err_no_byte, res_valid && ((status == ST_LEN) || (status == ST_OVERFLOW)), stream_byte == 8'd0)
    // Once keyed, the block never reports unkeyed again.
    `RC4KG_ASSERT_NEXT(a_keyed_sticky, keyed, keyed)

endmodule

// ----- sim/rc4_keystream_checker.sv -----
// Checker for the RC4 keystream generator: watches both channels, predicts each result.
// Depends on rc4kg_pkg for codes and widths; instantiated by tb_top beside the block.
`timescale 1ns / 1ps

module rc4_keystream_checker
    import rc4kg_pkg::*;
#(
    parameter int KEY_LEN = KEY_LEN_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    input  logic        cmd_ready,
    input  logic        opcode,
    input  logic [7:0]  key_byte,
    input  logic        key_last,
    input  logic        res_valid,
    input  logic        res_ready,
    input  logic [7:0]  stream_byte,
    input  logic [1:0]  status,
    input  logic        keyed,
    output int unsigned mismatches,
    output int unsigned outstanding
);

    typedef struct packed {
        logic [7:0] stream;
        logic [1:0] status;
        logic       keyed;
    } rc4_result_t;

    // Predicted cipher state
    logic [7:0]         sbox [PERM_SIZE];
    logic [7:0]         key_mem [KEY_LEN];
    logic [COUNT_W-1:0] key_cnt;
    logic [7:0]         idx_i;
    logic [7:0]         idx_j;
    logic               is_keyed;

    rc4_result_t pending_results [$];
    rc4_result_t want;
    rc4_result_t got;
    rc4_result_t fresh;

    task automatic swap_sbox(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] t;
        t       = sbox[a];
        sbox[a] = sbox[b];
        sbox[b] = t;
    endtask

    // Advances the predicted state by one item and returns its result.
    task automatic rc4_advance(input logic op, input logic [7:0] kb, input logic last,
                               output rc4_result_t r);
        logic [7:0] j;
        logic [7:0] f;
        r.stream = 8'h00;
        r.status = ST_OK;
        if (op == OP_LOAD) begin
            if (key_cnt < KEY_LEN) begin
                key_mem[key_cnt] = kb;
                key_cnt          = key_cnt + 1'b1;
            end
            else begin
                if (key_cnt < COUNT_MAX)
                    key_cnt = key_cnt + 1'b1;
                if (!last)
                    r.status = ST_OVERFLOW;
            end
            if (last) begin
                if (key_cnt == KEY_LEN) begin
                    for (int n = 0; n < PERM_SIZE; n++)
                        sbox[n] = 8'(n);
                    j = 8'h00;
                    for (int n = 0; n < PERM_SIZE; n++) begin
                        j = j + sbox[n] + key_mem[n % KEY_LEN];
                        swap_sbox(8'(n), j);
                    end
                    idx_i    = 8'h00;
                    idx_j    = 8'h00;
                    is_keyed = 1'b1;
                end
                else begin
                    r.status = ST_LEN;
                end
                key_cnt = '0;
            end
        end
        else if (!is_keyed) begin
            r.status = ST_UNKEYED;
        end
        else begin
            idx_i = idx_i + 8'd1;
            idx_j = idx_j + sbox[idx_i];
            swap_sbox(idx_i, idx_j);
            f        = sbox[idx_i] + sbox[idx_j];
            r.stream = sbox[f];
        end
        r.keyed = is_keyed;
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int n = 0; n < PERM_SIZE; n++)
                sbox[n] = 8'(n);
            key_cnt  = '0;
            idx_i    = 8'h00;
            idx_j    = 8'h00;
            is_keyed = 1'b0;
            pending_results.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else begin
            if (cmd_valid && cmd_ready) begin
                rc4_advance(opcode, key_byte, key_last, fresh);
                pending_results.insert(pending_results.size(), fresh);
            end
            if (res_valid && res_ready) begin
                got = '{stream: stream_byte, status: status, keyed: keyed};
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t checker: result with nothing expected: byte %02h st %0d k %0d",
                                 $realtime, got.stream, got.status, got.keyed);
                end
                else begin
                    want = pending_results.pop_front();
                    if (got.stream !== want.stream || got.status !== want.status ||
                        got.keyed !== want.keyed) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t checker: want byte %02h st %0d k %0d, got byte %02h st %0d k %0d",
                                     $realtime, want.stream, want.status, want.keyed,
                                     got.stream, got.status, got.keyed);
                    end
                end
            end
            outstanding = pending_results.size();
        end
    end

endmodule

// ----- sim/tb_top.sv -----
// Testbench top for rc4_keystream_generator: clock, reset, item stimulus and verdict.
// Depends on rc4kg_pkg, the block itself and rc4_keystream_checker.
`timescale 1ns / 1ps

module tb_top
    import rc4kg_pkg::*;
();

    localparam int KEY_BYTES    = KEY_LEN_DEFAULT;
    localparam int ITEM_TARGET  = 1170;   // directed part plus ~1150 random items
    // Slowest legal quiet stretch: a key schedule while a result waits out a
    // long receiver stall and the sender sits in a long gap.
    localparam int STALL_LIMIT  = 8000;
    localparam int SETTLE       = 20;
    localparam int SATURATE_LEN = 528;    // past the 9-bit count; a wrapping count would land on 16

    logic       clk;
    logic       rst_n;
    logic       cmd_valid;
    logic       cmd_ready;
    logic       opcode;
    logic [7:0] key_byte;
    logic       key_last;
    logic       res_valid;
    logic       res_ready;
    logic [7:0] stream_byte;
    logic [1:0] status;
    logic       keyed;

    int unsigned mismatches;
    int unsigned outstanding;

    // Run statistics for the summary
    int unsigned n_items;
    int unsigned n_keys_ok;
    int unsigned n_keys_bad;
    int unsigned n_gen;
    int unsigned quiet_cycles;
    bit          src_steady;    // sender runs back to back while set

    rc4_keystream_generator u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .opcode      (opcode),
        .key_byte    (key_byte),
        .key_last    (key_last),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .stream_byte (stream_byte),
        .status      (status),
        .keyed       (keyed)
    );

    rc4_keystream_checker #(.KEY_LEN(KEY_BYTES)) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .opcode      (opcode),
        .key_byte    (key_byte),
        .key_last    (key_last),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .stream_byte (stream_byte),
        .status      (status),
        .keyed       (keyed),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Watchdog: ends the run if neither channel moves for too long.
    always @(posedge clk) begin
        if (!rst_n || (cmd_valid && cmd_ready) || (res_valid && res_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_top: no handshake for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, outstanding);
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // Gap before the next item: mostly none, some short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (src_steady || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Drives one item at the current falling edge, holds it until accepted,
    // then either leaves valid up for the next call or drops it for a gap.
    // Always returns at a falling edge.
    task automatic send_item(input logic op, input logic [7:0] kb, input logic last);
        int gap;
        cmd_valid <= 1'b1;
        opcode    <= op;
        key_byte  <= kb;
        key_last  <= last;
        do
            @(posedge clk);
        while (!cmd_ready);
        n_items++;
        if (op == OP_GEN)
            n_gen++;
        @(negedge clk);
        gap = pick_gap();
        if (gap > 0) begin
            // junk payload while idle, so every bit toggles off the handshake too
            cmd_valid <= 1'b0;
            opcode    <= 1'($urandom);
            key_byte  <= 8'($urandom);
            key_last  <= 1'($urandom);
            repeat (gap) @(negedge clk);
        end
    endtask

    // A key of len bytes with random content, last flag on the final byte.
    task automatic send_key(input int len);
        for (int n = 0; n < len; n++)
            send_item(OP_LOAD, 8'($urandom), n == len - 1);
        if (len == KEY_BYTES)
            n_keys_ok++;
        else
            n_keys_bad++;
    endtask

    // Keystream requests; key_last is meaningless here and is randomized.
    task automatic send_gens(input int count);
        repeat (count) send_item(OP_GEN, 8'($urandom), 1'($urandom));
    endtask

    // Holds the sender off until every expected result has come back.
    task automatic drain();
        cmd_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    // Receiver: random stalls, short mostly, a few long, and steady stretches.
    initial begin : sink
        int hold;
        int r;
        hold      = 0;
        res_ready = 1'b0;
        wait (rst_n);
        forever begin
            @(negedge clk);
            if (hold > 0) begin
                hold--;
            end
            else begin
                r = $urandom_range(0, 99);
                if (r < 8) begin
                    res_ready <= 1'b1;
                    hold = $urandom_range(100, 400);
                end
                else if (r < 60) begin
                    res_ready <= 1'b1;
                    hold = $urandom_range(0, 6);
                end
                else if (r < 92) begin
                    res_ready <= 1'b0;
                    hold = $urandom_range(0, 3);
                end
                else begin
                    res_ready <= 1'b0;
                    hold = $urandom_range(10, 50);
                end
            end
        end
    end

    initial begin : stimulus
        int  r;
        bit  long_done;
        long_done  = 1'b0;
        src_steady = 1'b0;
        n_items    = 0;
        n_keys_ok  = 0;
        n_keys_bad = 0;
        n_gen      = 0;
        rst_n      = 1'b0;
        cmd_valid  = 1'b0;
        opcode     = OP_LOAD;
        key_byte   = 8'h00;
        key_last   = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part.
        // Keystream requests before any key: not-keyed status, key_last ignored.
        send_item(OP_GEN, 8'hFF, 1'b1);
        send_item(OP_GEN, 8'h00, 1'b0);
        // One-byte key closed early: length error, stays unkeyed.
        send_item(OP_LOAD, 8'hFF, 1'b1);
        n_keys_bad++;
        send_item(OP_GEN, 8'h5A, 1'b0);
        // Exact-length key opening with 00 and closing with FF.
        for (int n = 0; n < KEY_BYTES; n++)
            send_item(OP_LOAD, (n == 0) ? 8'h00 : (n == KEY_BYTES - 1) ? 8'hFF : 8'($urandom),
                      n == KEY_BYTES - 1);
        n_keys_ok++;
        send_item(OP_GEN, 8'h00, 1'b1);
        send_gens(3);
        // Let everything come home before the random part.
        drain();

        // Random part: mostly good keys followed by keystream runs, the rest
        // broken keys, overflowing keys, stray items and one count-saturating key.
        while (n_items < ITEM_TARGET) begin
            src_steady = ($urandom_range(0, 5) == 0);
            r = $urandom_range(0, 99);
            if (!long_done && n_items > 300) begin
                send_key(SATURATE_LEN);
                long_done = 1'b1;
            end
            else if (r < 60) begin
                send_key(KEY_BYTES);
                send_gens($urandom_range(0, 40));
            end
            else if (r < 72) begin
                send_gens($urandom_range(1, 30));
            end
            else if (r < 82) begin
                send_key($urandom_range(1, KEY_BYTES - 1));
            end
            else if (r < 92) begin
                send_key($urandom_range(KEY_BYTES + 1, KEY_BYTES + 8));
            end
            else begin
                repeat ($urandom_range(1, 6))
                    send_item(1'($urandom), 8'($urandom), 1'($urandom));
            end
            if ($urandom_range(0, 9) == 0)
                drain();
        end

        drain();
        repeat (SETTLE) @(negedge clk);

        $display("tb_top: %0d items: %0d full-length keys, %0d short or long keys, %0d keystream requests",
                 n_items, n_keys_ok, n_keys_bad, n_gen);
        $display("tb_top: %0d mismatches, %0d results still outstanding", mismatches, outstanding);
        if (mismatches == 0 && outstanding == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

// ----- rc4_keystream_generator.f -----
+incdir+rtl
rtl/rc4kg_pkg.sv
rtl/rc4kg_front.sv
rtl/rc4kg_queue.sv
rtl/rc4kg_back.sv
rtl/rc4_keystream_generator.sv
sim/rc4_keystream_checker.sv
sim/tb_top.sv
